// ----- sv/byte_fifo_with_end_marker_assert.svh -----
//------------------------------------------------------------------------------
// Assertion macros for the byte FIFO with end marker
// Clocked property wrappers used by the controller, the one file that carries assertions.
//------------------------------------------------------------------------------
`ifndef BYTE_FIFO_WITH_END_MARKER_ASSERT_SVH
`define BYTE_FIFO_WITH_END_MARKER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BFEM_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define BFEM_ASSERT_NEXT(name, clk, rst, trig, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- sv/bfem_pkg.sv -----
//------------------------------------------------------------------------------
// Byte FIFO with end marker: shared definitions
// Field widths, operation and status codes, controller states and the
// boundary string appended by finish and stop.
//------------------------------------------------------------------------------
package bfem_pkg;

   localparam int DEFAULT_DEPTH = 4096;
   localparam int OPCODE_W      = 3;
   localparam int BYTE_W        = 8;
   localparam int STATUS_W      = 2;
   localparam int FILL_W        = 13;

   // Boundary string "\r\n--this-is-a-boundary--\r\n".
   localparam int MARK_LEN   = 26;
   localparam int MARK_IDX_W = 5;
   localparam logic [BYTE_W-1:0] MARK_BYTES [MARK_LEN] = '{
      8'd13, 8'd10, 8'h2d, 8'h2d, 8'h74, 8'h68, 8'h69, 8'h73, 8'h2d,
      8'h69, 8'h73, 8'h2d, 8'h61, 8'h2d, 8'h62, 8'h6f, 8'h75, 8'h6e,
      8'h64, 8'h61, 8'h72, 8'h79, 8'h2d, 8'h2d, 8'd13, 8'd10
   };

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE  = 3'd0,
      OP_READ   = 3'd1,
      OP_FINISH = 3'd2,
      OP_STOP   = 3'd3,
      OP_RESET  = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_REFUSED = 2'd1,
      ST_EMPTY   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_MARK
   } state_type;

   // Memory strobes from the controller to the storage array.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ----- sv/bfem_ram.sv -----
//------------------------------------------------------------------------------
// Byte FIFO storage
// Single-port synchronous byte memory with a registered read port.
//------------------------------------------------------------------------------
module bfem_ram #(
   parameter int DEPTH = bfem_pkg::DEFAULT_DEPTH
) (
   input  logic                                  clock,
   input  bfem_pkg::mem_ctl_type                 mem_ctl,
   input  logic [$clog2(DEPTH)-1:0]              mem_addr,
   input  logic [bfem_pkg::BYTE_W-1:0]           mem_wdata,
   output logic [bfem_pkg::BYTE_W-1:0]           mem_rdata
);
   import bfem_pkg::*;

   logic [BYTE_W-1:0] mem_array [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   // Write and read share the one address; the controller never asks for both.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_array[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= mem_array[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// ----- sv/bfem_ctrl.sv -----
//------------------------------------------------------------------------------
// Byte FIFO controller
// Holds the indices, fill count and ended flag, sequences reads through the
// memory and appends the boundary string one byte per cycle.
//------------------------------------------------------------------------------
`include "byte_fifo_with_end_marker_assert.svh"

module bfem_ctrl #(
   parameter int DEPTH = bfem_pkg::DEFAULT_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [bfem_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic [bfem_pkg::BYTE_W-1:0]           req_data_byte,
   output logic                                  busy,
   output logic                                  rsp_valid,
   output logic [bfem_pkg::BYTE_W-1:0]           rsp_read_byte,
   output logic [bfem_pkg::STATUS_W-1:0]         rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]            fill_count,
   output logic                                  ended,
   output bfem_pkg::mem_ctl_type                 mem_ctl,
   output logic [$clog2(DEPTH)-1:0]              mem_addr,
   output logic [bfem_pkg::BYTE_W-1:0]           mem_wdata,
   input  logic [bfem_pkg::BYTE_W-1:0]           mem_rdata
);
   import bfem_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type             state_ff, state_in;
   logic [AW-1:0]         wr_idx_ff, wr_idx_in;
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  ended_ff, ended_in;
   logic [MARK_IDX_W-1:0] mark_idx_ff, mark_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   status_type            rsp_status_ff, rsp_status_in;

   opcode_type    opcode;
   logic          accept;
   logic          full;
   logic          mark_push;
   logic          mark_last;
   logic [AW-1:0] wr_idx_next;
   logic [AW-1:0] rd_idx_next;

   assign opcode = opcode_type'(req_opcode);
   assign accept = start && (state_ff == S_IDLE);
   assign full   = (count_ff == CW'(DEPTH));

   // Circular index advance; the depth need not be a power of two.
   assign wr_idx_next = (wr_idx_ff == AW'(DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
   assign rd_idx_next = (rd_idx_ff == AW'(DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;

   // The boundary stops at its last byte or when the storage fills up.
   assign mark_push = !full;
   assign mark_last = !mark_push || (mark_idx_ff == MARK_IDX_W'(MARK_LEN - 1)) ||
                      (count_ff == CW'(DEPTH - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (opcode) inside
                  OP_READ:            state_in = (count_ff != '0) ? S_READ : S_IDLE;
                  OP_FINISH, OP_STOP: state_in = S_MARK;
                  default:            state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         S_MARK: begin
            state_in = mark_last ? S_IDLE : S_MARK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath updates, memory requests and the result word.
   always_comb begin
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      count_in      = count_ff;
      ended_in      = ended_ff;
      mark_idx_in   = mark_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_byte_in   = '0;
      rsp_status_in = ST_DONE;
      mem_ctl       = '0;
      mem_addr      = wr_idx_ff;
      mem_wdata     = req_data_byte;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (opcode)
                  OP_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (!full && !ended_ff) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_idx_in     = wr_idx_next;
                        count_in      = count_ff + 1'b1;
                     end else begin
                        rsp_status_in = ST_REFUSED;
                     end
                  end
                  OP_READ: begin
                     if (count_ff != '0) begin
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = rd_idx_ff;
                        rd_idx_in     = rd_idx_next;
                        count_in      = count_ff - 1'b1;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end
                  end
                  OP_FINISH: begin
                     mark_idx_in = '0;
                  end
                  OP_STOP: begin
                     wr_idx_in   = '0;
                     rd_idx_in   = '0;
                     count_in    = '0;
                     mark_idx_in = '0;
                  end
                  OP_RESET: begin
                     wr_idx_in    = '0;
                     rd_idx_in    = '0;
                     count_in     = '0;
                     ended_in     = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = mem_rdata;
         end
         S_MARK: begin
            mem_wdata = MARK_BYTES[mark_idx_ff];
            if (mark_push) begin
               mem_ctl.wr_en = 1'b1;
               wr_idx_in     = wr_idx_next;
               count_in      = count_ff + 1'b1;
               mark_idx_in   = mark_idx_ff + 1'b1;
            end
            if (mark_last) begin
               ended_in     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         ended_ff     <= 1'b0;
         mark_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         count_ff     <= count_in;
         ended_ff     <= ended_in;
         mark_idx_ff  <= mark_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;
   assign rsp_status    = rsp_status_ff;
   assign fill_count    = count_ff;
   assign ended         = ended_ff;

   // Checks on the controller.
   `BFEM_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "fill count above depth")
   `BFEM_ASSERT_ALWAYS(a_mark_index, clock, reset, (state_ff != S_MARK) || (mark_idx_ff < MARK_IDX_W'(MARK_LEN)), "boundary index overrun")
   `BFEM_ASSERT_NEXT(a_read_done, clock, reset, state_ff == S_READ, rsp_valid_ff && (state_ff == S_IDLE), "read result missing")
   `BFEM_ASSERT_NEXT(a_write_refused, clock, reset, accept && (opcode == OP_WRITE) && ended_ff, rsp_valid_ff && (rsp_status_ff == ST_REFUSED), "write after end accepted")

endmodule

// ----- sv/byte_fifo_with_end_marker.sv -----
// Write, reset and unused codes: result one cycle after acceptance; busy stays low,
// so one such word can be accepted every cycle.
// Read: the memory's registered read port feeds the result register in the read state.
// Finish and stop: one memory write per cycle, one per boundary byte, until the
// last byte or a full store; a finish on a full store writes no byte. No stalls.
// Synchronous reset clears indices, count and flag at once; storage is not swept.
//------------------------------------------------------------------------------
// Byte FIFO with end marker
// Circular byte FIFO with a boundary string appended on finish and stop.
//------------------------------------------------------------------------------
module byte_fifo_with_end_marker #(
   parameter int DEPTH = bfem_pkg::DEFAULT_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [bfem_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic [bfem_pkg::BYTE_W-1:0]           req_data_byte,
   output logic                                  rsp_valid,
   output logic [bfem_pkg::BYTE_W-1:0]           rsp_read_byte,
   output logic [bfem_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bfem_pkg::FILL_W-1:0]           rsp_fill_level,
   output logic                                  rsp_finished_flag
);
   import bfem_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   mem_ctl_type          mem_ctl;
   logic [AW-1:0]        mem_addr;
   logic [BYTE_W-1:0]    mem_wdata;
   logic [BYTE_W-1:0]    mem_rdata;
   logic [CW-1:0]        fill_count;
   logic [CW+FILL_W-1:0] fill_ext;

   bfem_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_opcode    (req_opcode),
      .req_data_byte (req_data_byte),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_read_byte (rsp_read_byte),
      .rsp_status    (rsp_status),
      .fill_count    (fill_count),
      .ended         (rsp_finished_flag),
      .mem_ctl       (mem_ctl),
      .mem_addr      (mem_addr),
      .mem_wdata     (mem_wdata),
      .mem_rdata     (mem_rdata)
   );

   bfem_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // The reported fill level is the count cut or padded to the field width.
   assign fill_ext       = {{FILL_W{1'b0}}, fill_count};
   assign rsp_fill_level = fill_ext[FILL_W-1:0];

endmodule

// ----- tb/sv/tb_byte_fifo_with_end_marker.sv -----
//------------------------------------------------------------------------------
// Testbench for the byte FIFO with end marker
// Drives command words through the start/busy handshake and checks each result
// strobe against an in-bench model of the circular store, its fill level and
// the ended flag. The run covers a short directed part and a long random part
// with varying sender gaps.
//------------------------------------------------------------------------------
module tb_byte_fifo_with_end_marker;
   timeunit 1ns;
   timeprecision 1ps;
   import bfem_pkg::*;

   localparam int FIFO_DEPTH     = DEFAULT_DEPTH;
   localparam int RANDOM_WORDS   = 1430;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_REPORTS    = 50;

   // Opcodes with no defined operation.
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

   // Scoreboard: keeps a model of the store and the queue of expected results.
   class fifo_scoreboard;
      typedef struct packed {
         logic [BYTE_W-1:0]   read_byte;
         logic [STATUS_W-1:0] status;
         logic [FILL_W-1:0]   fill_level;
         logic                finished;
      } outcome_type;

      outcome_type       outcome_q[$];
      logic [BYTE_W-1:0] contents [FIFO_DEPTH];
      int unsigned       wr_slot;
      int unsigned       rd_slot;
      int unsigned       held;
      bit                ended;
      int unsigned       errors;

      function void store_byte(logic [BYTE_W-1:0] b);
         contents[wr_slot] = b;
         wr_slot = (wr_slot + 1 == FIFO_DEPTH) ? 0 : wr_slot + 1;
         held++;
      endfunction

      function void empty_store();
         wr_slot = 0;
         rd_slot = 0;
         held    = 0;
      endfunction

      // The boundary goes in only as far as space allows; the flag is set anyway.
      function void append_boundary();
         for (int k = 0; k < MARK_LEN && held < FIFO_DEPTH; k++)
            store_byte(MARK_BYTES[k]);
         ended = 1'b1;
      endfunction

      // Apply one accepted word to the model and queue the result it causes.
      function void note_input(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] d);
         outcome_type r;
         r = '0;
         r.status = ST_DONE;
         case (op)
            OP_WRITE: begin
               if (held < FIFO_DEPTH && !ended) store_byte(d);
               else r.status = ST_REFUSED;
            end
            OP_READ: begin
               if (held > 0) begin
                  r.read_byte = contents[rd_slot];
                  rd_slot = (rd_slot + 1 == FIFO_DEPTH) ? 0 : rd_slot + 1;
                  held--;
               end else begin
                  r.status = ST_EMPTY;
               end
            end
            OP_FINISH: append_boundary();
            OP_STOP: begin
               empty_store();
               append_boundary();
            end
            OP_RESET: begin
               empty_store();
               ended = 1'b0;
            end
            default: ;
         endcase
         r.fill_level = FILL_W'(held);
         r.finished   = ended;
         outcome_q.push_back(r);
      endfunction

      function void report_field(string field, logic [15:0] want, logic [15:0] got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      endfunction

      // Compare one result strobe with the oldest expectation.
      function void check_result(logic [BYTE_W-1:0] rd, logic [STATUS_W-1:0] st,
                                 logic [FILL_W-1:0] fill, logic flag);
         outcome_type want;
         if (outcome_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t ns: result with none expected, expected nothing, got %0d/%0d/%0d/%0d",
                        $time, rd, st, fill, flag);
            return;
         end
         want = outcome_q.pop_front();
         if (rd !== want.read_byte)
            report_field("read_byte", 16'(want.read_byte), 16'(rd));
         if (st !== want.status)
            report_field("status", 16'(want.status), 16'(st));
         if (fill !== want.fill_level)
            report_field("fill_level", 16'(want.fill_level), 16'(fill));
         if (flag !== want.finished)
            report_field("finished_flag", 16'(want.finished), 16'(flag));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OPCODE_W-1:0] req_opcode;
   logic [BYTE_W-1:0]   req_data_byte;
   logic                rsp_valid;
   logic [BYTE_W-1:0]   rsp_read_byte;
   logic [STATUS_W-1:0] rsp_status;
   logic [FILL_W-1:0]   rsp_fill_level;
   logic                rsp_finished_flag;

   fifo_scoreboard sb = new;
   int unsigned    idle_pct = 8;
   int unsigned    quiet_cycles = 0;

   byte_fifo_with_end_marker #(.DEPTH(FIFO_DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_status        (rsp_status),
      .rsp_fill_level    (rsp_fill_level),
      .rsp_finished_flag (rsp_finished_flag)
   );

   always #6 clock = ~clock;

   // Results are checked before the word accepted at the same edge is noted.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_read_byte, rsp_status, rsp_fill_level, rsp_finished_flag);
      if (!reset && start && !busy)
         sb.note_input(req_opcode, req_data_byte);
   end

   // Watchdog: ends the run if neither side moves a word for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("byte_fifo_with_end_marker verification failed");
         $finish;
      end
   end

   // Offer one word, sometimes with a random gap first, and hold it until accepted.
   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] d);
      if ($urandom_range(99) < idle_pct) begin
         start         <= 1'b0;
         req_opcode    <= OPCODE_W'($urandom);
         req_data_byte <= BYTE_W'($urandom);
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start         <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Hold off the sender until every expected result has come back.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.outcome_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned         roll;
      logic [OPCODE_W-1:0] op;

      reset         <= 1'b1;
      start         <= 1'b0;
      req_opcode    <= OP_WRITE;
      req_data_byte <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed words: empty read, extreme bytes, spare codes, repeated finish.
      send_word(OP_READ, 8'hff);
      send_word(OP_WRITE, 8'h00);
      send_word(OP_WRITE, 8'hff);
      send_word(OP_WRITE, 8'ha5);
      send_word(OP_WRITE, 8'h5a);
      send_word(OP_READ, 8'h00);
      send_word(OP_READ, 8'h00);
      send_word(OP_SPARE_LO, 8'hff);
      send_word(OP_SPARE_LO + 3'd1, 8'h0f);
      send_word(OP_SPARE_HI, 8'hf0);
      send_word(OP_FINISH, 8'h00);
      send_word(OP_WRITE, 8'h77);
      send_word(OP_READ, 8'h00);
      send_word(OP_FINISH, 8'hff);
      send_word(OP_STOP, 8'h00);
      send_word(OP_READ, 8'h00);
      send_word(OP_WRITE, 8'h11);
      send_word(OP_RESET, 8'hff);
      send_word(OP_WRITE, 8'h80);
      send_word(OP_READ, 8'h01);
      send_word(OP_RESET, 8'h00);
      wait_drained();

      // Random words: mostly writes and reads, with resets often enough to
      // reopen the stream after a finish or stop.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 3) idle_pct = 48;
         else if (i == 2 * RANDOM_WORDS / 3) idle_pct = 0;
         if (i == RANDOM_WORDS / 2) wait_drained();
         roll = $urandom_range(99);
         if (roll < 46) op = OP_WRITE;
         else if (roll < 80) op = OP_READ;
         else if (roll < 84) op = OP_FINISH;
         else if (roll < 87) op = OP_STOP;
         else if (roll < 95) op = OP_RESET;
         else op = OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
         send_word(op, BYTE_W'($urandom));
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.outcome_q.size() == 0)
         $display("byte_fifo_with_end_marker verification clean");
      else
         $display("byte_fifo_with_end_marker verification failed");
      $finish;
   end

endmodule
